// ----- sv/afs_pkg.sv -----
// Shared constants, codes and types for the animation frame sequencer.
`timescale 1ns / 1ps
`default_nettype none

package afs_pkg;

    localparam int MAX_FRAMES    = 16;
    localparam int INTERVAL_BITS = 16;
    localparam int FRAME_W       = $clog2(MAX_FRAMES);
    localparam int KIND_W        = 3;
    localparam int COUNT_W       = $clog2(MAX_FRAMES + 1) + 1;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_PLAY   = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_RESUME = 3'd3,
        KIND_WRITE  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_ONE_SHOT = 2'd1,
        MODE_LOOP     = 2'd2,
        MODE_PINGPONG = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAY_MODE   = 2'd0,
        CFG_FRAME_COUNT = 2'd1,
        CFG_USE_TABLE   = 2'd2,
        CFG_UNIFORM_IVL = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic               playing;
        logic               advanced;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/animation_frame_sequencer_core.sv -----
// Top level: frame sequencer with per-item state update and a two-deep result buffer.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | in        | i_in_valid / o_in_ready    | i_kind, i_entry_index, i_entry_value
//  out     | out       | o_out_valid / i_out_ready  | o_frame_index, o_playing, o_advanced
//  cfg     | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_ready is high: the state update and interval table lookup
// finish in the cycle of the transfer, and the result is registered before it shows on the out channel.
// A result register plus one skid entry take one input transfer during an output stall;
// o_in_ready drops the cycle after, while both hold unsent results.
// Reset (synchronous, active low) clears the run state, the registers and both buffers;
// the interval table is not cleared and must be written before it is used.
`timescale 1ns / 1ps
`default_nettype none

module animation_frame_sequencer_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output      logic                                  o_in_ready,
    input  wire logic [afs_pkg::KIND_W-1:0]            i_kind,
    input  wire logic [afs_pkg::FRAME_W-1:0]           i_entry_index,
    input  wire logic [afs_pkg::INTERVAL_BITS-1:0]     i_entry_value,
    output      logic                                  o_out_valid,
    input  wire logic                                  i_out_ready,
    output      logic [afs_pkg::FRAME_W-1:0]           o_frame_index,
    output      logic                                  o_playing,
    output      logic                                  o_advanced,
    input  wire logic                                  i_cfg_we,
    input  wire logic [afs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [afs_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import afs_pkg::*;

    // configuration
    t_mode                    r_mode;
    logic [4:0]               r_frame_count;
    logic                     r_use_table;
    logic [INTERVAL_BITS-1:0] r_uniform;

    // run state
    logic [FRAME_W-1:0]       r_frame,     n_frame;
    logic                     r_running,   n_running;
    logic                     r_back,      n_back;
    logic [INTERVAL_BITS-1:0] r_countdown, n_countdown;
    logic [INTERVAL_BITS-1:0] r_table [MAX_FRAMES];

    // result buffers
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid, n_result;

    logic               in_xfer, out_xfer;
    logic [FRAME_W-1:0] last;
    logic               load;
    logic               adv;
    t_kind              kind;

    assign kind       = t_kind'(i_kind);
    assign o_in_ready = !r_skid_valid;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;

    // last valid frame, with frame count clamped to 1..MAX_FRAMES
    always_comb begin
        if (r_frame_count == 5'd0) begin
            last = '0;
        end else if ({{(COUNT_W > 5 ? COUNT_W - 5 : 0){1'b0}}, r_frame_count}
                     > COUNT_W'(MAX_FRAMES)) begin
            last = FRAME_W'(MAX_FRAMES - 1);
        end else begin
            last = FRAME_W'(r_frame_count - 5'd1);
        end
    end

    // next run state for the item at the input
    always_comb begin
        n_frame     = r_frame;
        n_running   = r_running;
        n_back      = r_back;
        n_countdown = r_countdown;
        load        = 1'b0;
        adv         = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (r_running) begin
                    if (r_countdown <= INTERVAL_BITS'(1)) begin
                        adv = 1'b1;
                        case (r_mode)
                            MODE_ONE_SHOT: begin
                                if (r_frame >= last) begin
                                    n_running = 1'b0;
                                end else begin
                                    n_frame = r_frame + 1'b1;
                                    load    = 1'b1;
                                end
                            end
                            MODE_LOOP: begin
                                n_frame = (r_frame >= last) ? '0 : r_frame + 1'b1;
                                load    = 1'b1;
                            end
                            MODE_PINGPONG: begin
                                load = 1'b1;
                                if (last == '0) begin
                                    n_frame = '0;
                                    n_back  = 1'b0;
                                end else if (!r_back) begin
                                    if (r_frame >= last - 1'b1) begin
                                        n_back  = 1'b1;
                                        n_frame = (r_frame >= last) ? last : r_frame + 1'b1;
                                    end else begin
                                        n_frame = r_frame + 1'b1;
                                    end
                                end else if (r_frame == '0) begin
                                    n_back  = 1'b0;
                                    n_frame = FRAME_W'(1);
                                end else begin
                                    if (r_frame == FRAME_W'(1)) begin
                                        n_back = 1'b0;
                                    end
                                    n_frame = r_frame - 1'b1;
                                end
                            end
                            default: begin
                                n_running = 1'b0;
                            end
                        endcase
                    end else begin
                        n_countdown = r_countdown - 1'b1;
                    end
                end
            end
            KIND_PLAY: begin
                if (r_mode != MODE_NONE) begin
                    n_back    = 1'b0;
                    n_frame   = '0;
                    n_running = 1'b1;
                    load      = 1'b1;
                end
            end
            KIND_STOP: begin
                n_running = 1'b0;
            end
            KIND_RESUME: begin
                if (r_mode != MODE_NONE) begin
                    n_running = 1'b1;
                    load      = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // reload the delay of the frame shown next
        if (load) begin
            n_countdown = r_use_table ? r_table[n_frame] : r_uniform;
        end
        n_result.frame_index = n_frame;
        n_result.playing     = n_running;
        n_result.advanced    = adv;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_NONE;
            r_frame_count <= 5'd1;
            r_use_table   <= 1'b0;
            r_uniform     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PLAY_MODE:   r_mode        <= t_mode'(i_cfg_data[1:0]);
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[4:0];
                CFG_USE_TABLE:   r_use_table   <= i_cfg_data[0];
                CFG_UNIFORM_IVL: r_uniform     <= i_cfg_data[INTERVAL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // run state advances on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_running   <= 1'b0;
            r_back      <= 1'b0;
            r_countdown <= '0;
        end else if (in_xfer) begin
            r_frame     <= n_frame;
            r_running   <= n_running;
            r_back      <= n_back;
            r_countdown <= n_countdown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && kind == KIND_WRITE) begin
            r_table[i_entry_index] <= i_entry_value;
        end
    end

    // result register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_xfer) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_xfer) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_xfer) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_index = r_out.frame_index;
    assign o_playing     = r_out.playing;
    assign o_advanced    = r_out.advanced;

endmodule

`default_nettype wire

// ----- sv/afs_checker.sv -----
// Port-level checks for the frame sequencer top level, bound to it.
`timescale 1ns / 1ps
`default_nettype none

module afs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready
);

    // hold an offered result until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // reset empties the result buffers
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result buffer not empty after reset");

    // input backpressure only while a result is waiting
    a_ready_low_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // an input transfer into an empty buffer shows a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> o_out_valid)
        else $error("result missing after input transfer");

endmodule

bind animation_frame_sequencer_core afs_checker u_afs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the frame sequencer core: directed script, then random traffic.
`timescale 1ns / 1ps

module testbench;
    import afs_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 125;
    localparam int SHOWN_ERRORS  = 10;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_LAST  = 3'd7;

    typedef struct {
        bit                      regs;
        t_mode                   mode;
        logic [4:0]              frames;
        bit                      tbl;
        logic [15:0]             ivl;
        logic [KIND_W-1:0]       kind;
        logic [FRAME_W-1:0]      idx;
        logic [INTERVAL_BITS-1:0] val;
        bit                      typed;
        t_result                 want;
    } t_step_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [KIND_W-1:0]         i_kind;
    logic [FRAME_W-1:0]        i_entry_index;
    logic [INTERVAL_BITS-1:0]  i_entry_value;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [FRAME_W-1:0]        o_frame_index;
    logic                      o_playing;
    logic                      o_advanced;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    // typed expectation travels with the payload of a directed row
    bit      row_typed;
    t_result row_want;

    // predictor copy of registers and run state
    t_mode        reg_mode;
    logic [4:0]   reg_frames;
    logic         reg_tbl;
    logic [15:0]  reg_ivl;
    int           seq_frame;
    bit           seq_run;
    bit           seq_back;
    int           seq_wait;
    logic [15:0]  ivl_table [MAX_FRAMES];

    t_result   pending_reports [$];
    t_step_row script [$];

    int errors;
    int n_items;
    int n_checked;
    int n_steps;
    int n_settings;
    int cycle_cnt;

    animation_frame_sequencer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_frame_index (o_frame_index),
        .o_playing     (o_playing),
        .o_advanced    (o_advanced),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reload_countdown();
        seq_wait = reg_tbl ? int'(ivl_table[seq_frame]) : int'(reg_ivl);
    endfunction

    function automatic t_result next_report(logic [KIND_W-1:0] kind, logic [FRAME_W-1:0] idx,
                                            logic [INTERVAL_BITS-1:0] val);
        int      n;
        bit      fired;
        t_result r;
        fired = 1'b0;
        n = (reg_frames == 0) ? 1 : ((reg_frames > MAX_FRAMES) ? MAX_FRAMES : int'(reg_frames));
        case (kind)
            KIND_TICK: begin
                if (seq_run) begin
                    if (seq_wait <= 1) begin
                        fired = 1'b1;
                        case (reg_mode)
                            MODE_ONE_SHOT: begin
                                if (seq_frame + 1 >= n) begin
                                    seq_run = 1'b0;
                                end else begin
                                    seq_frame++;
                                    reload_countdown();
                                end
                            end
                            MODE_LOOP: begin
                                seq_frame = (seq_frame + 1 >= n) ? 0 : seq_frame + 1;
                                reload_countdown();
                            end
                            MODE_PINGPONG: begin
                                if (n < 2) begin
                                    seq_frame = 0;
                                    seq_back  = 1'b0;
                                end else if (!seq_back) begin
                                    if (seq_frame + 1 >= n - 1) begin
                                        seq_back  = 1'b1;
                                        seq_frame = (seq_frame + 1 > n - 1) ? n - 1 : seq_frame + 1;
                                    end else begin
                                        seq_frame++;
                                    end
                                end else if (seq_frame == 0) begin
                                    seq_back  = 1'b0;
                                    seq_frame = 1;
                                end else begin
                                    if (seq_frame == 1)
                                        seq_back = 1'b0;
                                    seq_frame--;
                                end
                                reload_countdown();
                            end
                            default: seq_run = 1'b0;
                        endcase
                    end else begin
                        seq_wait--;
                    end
                end
            end
            KIND_PLAY: begin
                if (reg_mode != MODE_NONE) begin
                    seq_back  = 1'b0;
                    seq_frame = 0;
                    seq_run   = 1'b1;
                    reload_countdown();
                end
            end
            KIND_STOP: seq_run = 1'b0;
            KIND_RESUME: begin
                if (reg_mode != MODE_NONE) begin
                    seq_run = 1'b1;
                    reload_countdown();
                end
            end
            KIND_WRITE: ivl_table[idx] = val;
            default: ;
        endcase
        r.frame_index = seq_frame[FRAME_W-1:0];
        r.playing     = seq_run;
        r.advanced    = fired;
        return r;
    endfunction

    task automatic note_error(input string what, input t_result want, input t_result got);
        errors++;
        if (errors <= SHOWN_ERRORS)
            $display({"%0t: %s: expected frame %0d playing %0b advanced %0b, ",
                      "got frame %0d playing %0b advanced %0b"},
                     $realtime, what, want.frame_index, want.playing, want.advanced,
                     got.frame_index, got.playing, got.advanced);
    endtask

    // compare results, predict accepted items, track register writes
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        t_result pred;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{frame_index: o_frame_index, playing: o_playing, advanced: o_advanced};
                if (pending_reports.size() == 0) begin
                    note_error("unexpected result", '0, got);
                end else begin
                    want = pending_reports.pop_front();
                    n_checked++;
                    if (got.advanced === 1'b1)
                        n_steps++;
                    if (got.frame_index !== want.frame_index || got.playing !== want.playing ||
                        got.advanced !== want.advanced)
                        note_error("mismatch", want, got);
                end
            end
            if (i_in_valid && o_in_ready) begin
                pred = next_report(i_kind, i_entry_index, i_entry_value);
                pending_reports.push_back(row_typed ? row_want : pred);
                n_items++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PLAY_MODE:   reg_mode   = t_mode'(i_cfg_data[1:0]);
                    CFG_FRAME_COUNT: reg_frames = i_cfg_data[4:0];
                    CFG_USE_TABLE:   reg_tbl    = i_cfg_data[0];
                    CFG_UNIFORM_IVL: reg_ivl    = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // receiver stalls on its own pattern, switching to a new random style after each random span
    initial begin : rx_pattern
        int style;
        int span;
        int hold;
        style = 0;
        span  = 0;
        hold  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(100, 400);
            end
            span--;
            case (style)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 1);
                2: begin
                    if (hold > 0) begin
                        hold--;
                        i_out_ready <= 1'b0;
                    end else if ($urandom_range(0, 9) == 0) begin
                        hold = $urandom_range(2, 7);
                        i_out_ready <= 1'b0;
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
                default: i_out_ready <= (span % 3 != 0);
            endcase
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles with %0d results outstanding", cycle_cnt,
                 pending_reports.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the transfer, valid held high
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [FRAME_W-1:0] idx,
                             input logic [INTERVAL_BITS-1:0] val, input bit typed,
                             input t_result want);
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= idx;
        i_entry_value <= val;
        row_typed     <= typed;
        row_want      <= want;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // hold off until every expected result has been seen
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_settings(input t_mode mode, input logic [4:0] frames, input bit tbl,
                                 input logic [15:0] ivl);
        logic [15:0] junk;
        junk = ($urandom_range(0, 1) == 1) ? 16'($urandom()) : 16'h0000;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PLAY_MODE;
        i_cfg_data  <= {junk[15:2], mode};
        @(negedge i_clk);
        i_cfg_index <= CFG_FRAME_COUNT;
        i_cfg_data  <= {junk[15:5], frames};
        @(negedge i_clk);
        i_cfg_index <= CFG_USE_TABLE;
        i_cfg_data  <= {junk[15:1], tbl};
        @(negedge i_clk);
        i_cfg_index <= CFG_UNIFORM_IVL;
        i_cfg_data  <= ivl;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        n_settings++;
    endtask

    function automatic void add_item(logic [KIND_W-1:0] kind, logic [FRAME_W-1:0] idx = 0,
                                     logic [INTERVAL_BITS-1:0] val = 0, bit typed = 0,
                                     logic [FRAME_W-1:0] f = 0, bit p = 0, bit a = 0);
        t_step_row row;
        row.regs   = 1'b0;
        row.mode   = MODE_NONE;
        row.frames = 5'd1;
        row.tbl    = 1'b0;
        row.ivl    = 16'd0;
        row.kind   = kind;
        row.idx    = idx;
        row.val    = val;
        row.typed  = typed;
        row.want   = '{frame_index: f, playing: p, advanced: a};
        script.push_back(row);
    endfunction

    function automatic void add_regs(t_mode mode, logic [4:0] frames, bit tbl, logic [15:0] ivl);
        t_step_row row;
        row.regs   = 1'b1;
        row.mode   = mode;
        row.frames = frames;
        row.tbl    = tbl;
        row.ivl    = ivl;
        row.kind   = KIND_TICK;
        row.idx    = '0;
        row.val    = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        script.push_back(row);
    endfunction

    initial begin : stimulus
        int          p;
        int          k;
        int          r;
        int          burst_left;
        bit          steady;
        logic [KIND_W-1:0]        kind;
        logic [FRAME_W-1:0]       idx;
        logic [INTERVAL_BITS-1:0] val;
        t_mode       m;
        logic [4:0]  fc;
        bit          tb;
        logic [15:0] iv;

        errors     = 0;
        n_items    = 0;
        n_checked  = 0;
        n_steps    = 0;
        n_settings = 0;
        reg_mode   = MODE_NONE;
        reg_frames = 5'd1;
        reg_tbl    = 1'b0;
        reg_ivl    = 16'd0;
        seq_frame  = 0;
        seq_run    = 1'b0;
        seq_back   = 1'b0;
        seq_wait   = 0;
        foreach (ivl_table[k])
            ivl_table[k] = 16'd0;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_TICK;
        i_entry_index = '0;
        i_entry_value = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_PLAY_MODE;
        i_cfg_data    = '0;
        row_typed     = 1'b0;
        row_want      = '0;

        // commands with nothing to play change nothing
        add_item(KIND_TICK,   0,  16'h0000, 1, 0, 0, 0);
        add_item(KIND_PLAY,   15, 16'hFFFF, 1, 0, 0, 0);
        add_item(KIND_RESUME, 0,  16'h0000, 1, 0, 0, 0);
        add_item(KIND_STOP,   15, 16'hFFFF, 1, 0, 0, 0);
        add_item(KIND_UNKNOWN_FIRST, 5, 16'h1234, 1, 0, 0, 0);
        add_item(KIND_UNKNOWN_LAST,  9, 16'hABCD, 1, 0, 0, 0);
        add_item(KIND_WRITE,  15, 16'hFFFF, 1, 0, 0, 0);
        add_item(KIND_WRITE,  0,  16'h0000, 1, 0, 0, 0);
        // one-shot with a zero delay: every tick while running steps, run ends on the last frame
        add_regs(MODE_ONE_SHOT, 5'd3, 1'b0, 16'd0);
        add_item(KIND_PLAY, 0, 0, 1, 0, 1, 0);
        add_item(KIND_TICK, 0, 0, 1, 1, 1, 1);
        add_item(KIND_TICK, 0, 0, 1, 2, 1, 1);
        add_item(KIND_TICK, 0, 0, 1, 2, 0, 1);
        add_item(KIND_TICK, 0, 0, 1, 2, 0, 0);
        // resume past the end of a shorter loop, then wrap
        add_regs(MODE_LOOP, 5'd2, 1'b0, 16'd2);
        add_item(KIND_RESUME, 0, 0, 1, 2, 1, 0);
        add_item(KIND_TICK,   0, 0, 1, 2, 1, 0);
        add_item(KIND_TICK,   0, 0, 1, 0, 1, 1);
        add_item(KIND_STOP,   0, 0, 1, 0, 0, 0);
        // ping-pong with a single frame holds frame 0
        add_regs(MODE_PINGPONG, 5'd1, 1'b0, 16'd1);
        add_item(KIND_PLAY, 0, 0, 1, 0, 1, 0);
        add_item(KIND_TICK, 0, 0, 1, 0, 1, 1);
        // bounce over four frames while still running
        add_regs(MODE_PINGPONG, 5'd4, 1'b0, 16'd0);
        for (k = 0; k < 6; k++)
            add_item(KIND_TICK);
        // mode switched to no play mid-run: the next step stops the run
        add_regs(MODE_NONE, 5'd4, 1'b0, 16'd0);
        add_item(KIND_TICK);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[k]) begin
            if (script[k].regs) begin
                settle();
                load_settings(script[k].mode, script[k].frames, script[k].tbl, script[k].ivl);
            end else begin
                send_item(script[k].kind, script[k].idx, script[k].val, script[k].typed,
                          script[k].want);
            end
        end

        // fill the whole interval table before any table lookup can happen
        for (k = 0; k < MAX_FRAMES; k++)
            send_item(KIND_WRITE, k[FRAME_W-1:0], 16'($urandom_range(0, 4)), 1'b0, '0);

        for (p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: begin m = MODE_ONE_SHOT; fc = 5'd16; tb = 1'b0; iv = 16'd0;     end
                1: begin m = MODE_LOOP;     fc = 5'd1;  tb = 1'b1; iv = 16'd3;     end
                2: begin m = MODE_PINGPONG; fc = 5'd16; tb = 1'b1; iv = 16'd3;     end
                3: begin m = MODE_PINGPONG; fc = 5'd2;  tb = 1'b0; iv = 16'd1;     end
                4: begin m = MODE_LOOP;     fc = 5'd0;  tb = 1'b0; iv = 16'd2;     end
                5: begin m = MODE_ONE_SHOT; fc = 5'd31; tb = 1'b1; iv = 16'd0;     end
                6: begin m = MODE_NONE;     fc = 5'd5;  tb = 1'b0; iv = 16'd1;     end
                7: begin m = MODE_LOOP;     fc = 5'd7;  tb = 1'b0; iv = 16'hFFFF;  end
                default: begin
                    m  = t_mode'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3));
                    fc = ($urandom_range(0, 7) == 0) ? 5'($urandom())
                                                     : 5'($urandom_range(1, 16));
                    tb = 1'($urandom_range(0, 1));
                    iv = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                     : 16'($urandom_range(0, 4));
                end
            endcase
            load_settings(m, fc, tb, iv);

            steady     = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 20);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (!steady && burst_left == 0) begin
                    idle_for(($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                         : $urandom_range(1, 3));
                    burst_left = $urandom_range(1, 20);
                end
                if (burst_left > 0)
                    burst_left--;
                // drain the block now and then mid-stream
                if ($urandom_range(0, 199) == 0)
                    settle();
                r   = $urandom_range(0, 99);
                idx = FRAME_W'($urandom_range(0, MAX_FRAMES - 1));
                val = 16'($urandom());
                if (r < 68) begin
                    kind = KIND_TICK;
                end else if (r < 73) begin
                    kind = KIND_PLAY;
                end else if (r < 78) begin
                    kind = KIND_STOP;
                end else if (r < 85) begin
                    kind = KIND_RESUME;
                end else if (r < 96) begin
                    kind = KIND_WRITE;
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        val = 16'($urandom_range(0, 5));
                    else if (r < 97)
                        val = 16'($urandom_range(0, 40));
                end else begin
                    kind = KIND_W'($urandom_range(KIND_UNKNOWN_FIRST, KIND_UNKNOWN_LAST));
                end
                send_item(kind, idx, val, 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(negedge i_clk);

        $display("covered %0d items under %0d register settings: %0d results checked",
                 n_items, n_settings, n_checked);
        $display("%0d frame steps seen", n_steps);
        if (errors > SHOWN_ERRORS)
            $display("%0d further mismatches not shown", errors - SHOWN_ERRORS);
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/afs_pkg.sv
sv/animation_frame_sequencer_core.sv
sv/afs_checker.sv
test/testbench.sv
